// ===== design/osc_pkg.sv =====
package osc_pkg;

  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;

  localparam int H_BITS     = COORD_BITS - 1;
  localparam int D_BITS     = COORD_BITS + 1;
  localparam int T_BITS     = 17;
  localparam int Q_BITS     = 15;
  localparam int TRIG_BITS  = 16;
  localparam int DOT_BITS   = 2 * TRIG_BITS + 1;
  localparam int ADOT_BITS  = DOT_BITS - 1;
  localparam int PROJ_BITS  = D_BITS + TRIG_BITS + 1;
  localparam int APROJ_BITS = PROJ_BITS - 1;
  localparam int PROD_BITS  = ADOT_BITS + H_BITS;
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam int SINE_DEPTH = 4;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef struct packed {
    logic signed [TRIG_BITS-1:0] c;
    logic signed [TRIG_BITS-1:0] s;
  } trig_t;

  function automatic trig_t quad_map(input logic [1:0] quad,
                                     input logic [Q_BITS-1:0] st,
                                     input logic [Q_BITS-1:0] sc);
    trig_t                       r;
    logic signed [TRIG_BITS-1:0] pt;
    logic signed [TRIG_BITS-1:0] pc;
    pt = $signed(TRIG_BITS'(st));
    pc = $signed(TRIG_BITS'(sc));
    case (quad)
      QUAD_0: begin
        r.s = pt;
        r.c = pc;
      end
      QUAD_1: begin
        r.s = pc;
        r.c = -pt;
      end
      QUAD_2: begin
        r.s = -pt;
        r.c = -pc;
      end
      default: begin
        r.s = -pc;
        r.c = pt;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== design/osc_if.sv =====
interface osc_in_if;
  import osc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_center_x;
  logic signed [COORD_BITS-1:0] a_center_y;
  logic [H_BITS-1:0]            a_half_width;
  logic [H_BITS-1:0]            a_half_height;
  logic [ANGLE_BITS-1:0]        a_angle;
  logic signed [COORD_BITS-1:0] b_center_x;
  logic signed [COORD_BITS-1:0] b_center_y;
  logic [H_BITS-1:0]            b_half_width;
  logic [H_BITS-1:0]            b_half_height;
  logic [ANGLE_BITS-1:0]        b_angle;

  modport source (output valid, a_center_x, a_center_y, a_half_width, a_half_height, a_angle,
                  b_center_x, b_center_y, b_half_width, b_half_height, b_angle,
                  input ready);
  modport sink (input valid, a_center_x, a_center_y, a_half_width, a_half_height, a_angle,
                b_center_x, b_center_y, b_half_width, b_half_height, b_angle,
                output ready);
endinterface

interface osc_out_if;
  logic valid;
  logic ready;
  logic collides;

  modport source (output valid, collides, input ready);
  modport sink (input valid, collides, output ready);
endinterface

// ===== design/oriented_rect_sat_collision.sv =====
// Separating axis collision test for two oriented rectangles.
// Requests arrive on in_i: centre, half extents and binary angle of each
// rectangle. Each request yields exactly one result on out_o, whose
// collides bit is set when the projections overlap on all four axes of
// the two rectangles; touching counts as overlap.
// The block is a seven-stage pipeline: four stages evaluate the sine
// polynomial, one forms the axes and their dot products, one multiplies
// by the half extents, and one sums and compares into the output register.
// A new request is taken in every cycle unless the receiver stalls.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and in_i.ready falls; nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline comes up empty.
module oriented_rect_sat_collision (
  input  logic      clk_i,
  input  logic      rst_ni,
  osc_in_if.sink    in_i,
  osc_out_if.source out_o
);
  import osc_pkg::*;

  localparam int DEPTH = SINE_DEPTH + 3;

  logic [DEPTH-1:0]        v_q;
  logic                    en;
  logic [T_BITS-1:0]       ta, tb, tca, tcb;
  logic [Q_BITS-1:0]       qa, qb, qca, qcb;
  logic signed [D_BITS-1:0] dx_d, dy_d;
  logic signed [D_BITS-1:0] dx_q [SINE_DEPTH];
  logic signed [D_BITS-1:0] dy_q [SINE_DEPTH];
  logic [3:0][H_BITS-1:0]  h_q [SINE_DEPTH];
  logic [1:0]              qda_q [SINE_DEPTH];
  logic [1:0]              qdb_q [SINE_DEPTH];
  logic                    hit;

  assign en         = !v_q[DEPTH-1] || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    ta   = T_BITS'((40'(in_i.a_angle[ANGLE_BITS-3:0]) << 18) >> ANGLE_BITS);
    tb   = T_BITS'((40'(in_i.b_angle[ANGLE_BITS-3:0]) << 18) >> ANGLE_BITS);
    tca  = T_BITS'(18'h10000 - 18'(ta));
    tcb  = T_BITS'(18'h10000 - 18'(tb));
    dx_d = D_BITS'(in_i.a_center_x) - D_BITS'(in_i.b_center_x);
    dy_d = D_BITS'(in_i.a_center_y) - D_BITS'(in_i.b_center_y);
  end

  osc_sine u_sin_a  (.clk_i(clk_i), .en_i(en), .t_i(ta),  .q_o(qa));
  osc_sine u_cos_a  (.clk_i(clk_i), .en_i(en), .t_i(tca), .q_o(qca));
  osc_sine u_sin_b  (.clk_i(clk_i), .en_i(en), .t_i(tb),  .q_o(qb));
  osc_sine u_cos_b  (.clk_i(clk_i), .en_i(en), .t_i(tcb), .q_o(qcb));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DEPTH-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q[0]  <= dx_d;
      dy_q[0]  <= dy_d;
      h_q[0]   <= {in_i.b_half_height, in_i.b_half_width,
                   in_i.a_half_height, in_i.a_half_width};
      qda_q[0] <= in_i.a_angle[ANGLE_BITS-1:ANGLE_BITS-2];
      qdb_q[0] <= in_i.b_angle[ANGLE_BITS-1:ANGLE_BITS-2];
      for (int i = 1; i < SINE_DEPTH; i++) begin
        dx_q[i]  <= dx_q[i-1];
        dy_q[i]  <= dy_q[i-1];
        h_q[i]   <= h_q[i-1];
        qda_q[i] <= qda_q[i-1];
        qdb_q[i] <= qdb_q[i-1];
      end
    end
  end

  osc_sat u_sat (
    .clk_i    (clk_i),
    .en_i     (en),
    .quad_a_i (qda_q[SINE_DEPTH-1]),
    .quad_b_i (qdb_q[SINE_DEPTH-1]),
    .st_a_i   (qa),
    .sc_a_i   (qca),
    .st_b_i   (qb),
    .sc_b_i   (qcb),
    .dx_i     (dx_q[SINE_DEPTH-1]),
    .dy_i     (dy_q[SINE_DEPTH-1]),
    .h_i      (h_q[SINE_DEPTH-1]),
    .hit_o    (hit)
  );

  assign out_o.valid    = v_q[DEPTH-1];
  assign out_o.collides = hit;
endmodule

// ===== design/osc_sine.sv =====
module osc_sine (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [osc_pkg::T_BITS-1:0] t_i,
  output logic [osc_pkg::Q_BITS-1:0] q_o
);
  import osc_pkg::*;

  logic [T_BITS-1:0] t1_q, t2_q, t3_q;
  logic [T_BITS-1:0] sq1_q, sq2_q;
  logic [15:0]       i2_q;
  logic [T_BITS-1:0] m3_q;
  logic [T_BITS-1:0] sq1_d, m3_d;
  logic [15:0]       i2_d;
  logic [T_BITS:0]   s4;
  logic [T_BITS:0]   r4;
  logic [Q_BITS-1:0] q_d, q_q;

  always_comb begin
    sq1_d = T_BITS'((34'(t_i) * 34'(t_i)) >> 16);
    i2_d  = 16'(32'd42047 - ((32'(sq1_q) * 32'd4639) >> 16));
    m3_d  = T_BITS'(36'd102944 - ((36'(sq2_q) * 36'(i2_q)) >> 16));
    s4    = (T_BITS + 1)'((36'(t3_q) * 36'(m3_q)) >> 16);
    r4    = (s4 + (T_BITS + 1)'(2)) >> 2;
    q_d   = (r4 > (T_BITS + 1)'(16384)) ? Q_BITS'(16384) : Q_BITS'(r4);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q  <= t_i;
      sq1_q <= sq1_d;
      t2_q  <= t1_q;
      sq2_q <= sq1_q;
      i2_q  <= i2_d;
      t3_q  <= t2_q;
      m3_q  <= m3_d;
      q_q   <= q_d;
    end
  end

  assign q_o = q_q;
endmodule

// ===== design/osc_sat.sv =====
module osc_sat (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [1:0]                         quad_a_i,
  input  logic [1:0]                         quad_b_i,
  input  logic [osc_pkg::Q_BITS-1:0]         st_a_i,
  input  logic [osc_pkg::Q_BITS-1:0]         sc_a_i,
  input  logic [osc_pkg::Q_BITS-1:0]         st_b_i,
  input  logic [osc_pkg::Q_BITS-1:0]         sc_b_i,
  input  logic signed [osc_pkg::D_BITS-1:0]  dx_i,
  input  logic signed [osc_pkg::D_BITS-1:0]  dy_i,
  input  logic [3:0][osc_pkg::H_BITS-1:0]    h_i,
  output logic                               hit_o
);
  import osc_pkg::*;

  trig_t                       ta, tb;
  logic signed [TRIG_BITS-1:0] ux [4];
  logic signed [TRIG_BITS-1:0] uy [4];
  logic signed [DOT_BITS-1:0]  dot;
  logic signed [PROJ_BITS-1:0] proj;
  logic [ADOT_BITS-1:0]        adot_d [4][4];
  logic [ADOT_BITS-1:0]        adot_q [4][4];
  logic [APROJ_BITS-1:0]       aproj_d [4];
  logic [APROJ_BITS-1:0]       aproj_q [4];
  logic [APROJ_BITS-1:0]       aproj2_q [4];
  logic [3:0][H_BITS-1:0]      h5_q;
  logic [PROD_BITS-1:0]        prod_q [4][4];
  logic [SUM_BITS-1:0]         rsum;
  logic [SUM_BITS-1:0]         lhs;
  logic                        hit_d, hit_q;

  always_comb begin
    ta = quad_map(quad_a_i, st_a_i, sc_a_i);
    tb = quad_map(quad_b_i, st_b_i, sc_b_i);
    ux[0] = ta.c;  uy[0] = ta.s;
    ux[1] = -ta.s; uy[1] = ta.c;
    ux[2] = tb.c;  uy[2] = tb.s;
    ux[3] = -tb.s; uy[3] = tb.c;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        dot = DOT_BITS'(ux[k]) * DOT_BITS'(ux[j]) + DOT_BITS'(uy[k]) * DOT_BITS'(uy[j]);
        adot_d[k][j] = dot[DOT_BITS-1] ? ADOT_BITS'(-dot) : ADOT_BITS'(dot);
      end
      proj = PROJ_BITS'(ux[k]) * PROJ_BITS'(dx_i) + PROJ_BITS'(uy[k]) * PROJ_BITS'(dy_i);
      aproj_d[k] = proj[PROJ_BITS-1] ? APROJ_BITS'(-proj) : APROJ_BITS'(proj);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adot_q  <= adot_d;
      aproj_q <= aproj_d;
      h5_q    <= h_i;
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[k][j] <= PROD_BITS'(adot_q[k][j]) * PROD_BITS'(h5_q[j]);
        end
      end
      aproj2_q <= aproj_q;
      hit_q    <= hit_d;
    end
  end

  always_comb begin
    hit_d = 1'b1;
    for (int k = 0; k < 4; k++) begin
      rsum = SUM_BITS'(prod_q[k][0]) + SUM_BITS'(prod_q[k][1])
           + SUM_BITS'(prod_q[k][2]) + SUM_BITS'(prod_q[k][3]);
      lhs  = SUM_BITS'(aproj2_q[k]) << 14;
      if (lhs > rsum) begin
        hit_d = 1'b0;
      end
    end
  end

  assign hit_o = hit_q;
endmodule
